// ----- design/hysteresis_thermostat_regulator_assert.svh -----
// Assertion macros used by the regulator RTL.
`ifndef HYSTERESIS_THERMOSTAT_REGULATOR_ASSERT_SVH
`define HYSTERESIS_THERMOSTAT_REGULATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define HTR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htr assertion failed");
`define HTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htr assertion failed");
`else
`define HTR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HTR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/htr_pkg.sv -----
`timescale 1ns / 1ps
package htr_pkg;

  localparam int SAMPLE_BITS  = 9;
  localparam int DUTY_MAX     = 100;
  localparam int DUTY_W       = 7;
  localparam int TEMP_LIMIT   = 100;
  localparam int TEMP_CLAMPED = 101;
  localparam int DUTY_RESET   = 100;

  // Signed width that holds any reading, band edge or their difference.
  localparam int RD_W   = SAMPLE_BITS + 2;
  // Width of the duty product: difference times an 8-bit signed gain.
  localparam int PROD_W = RD_W + 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGULATION_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN            = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ASSIGNED = 3'd7;

  typedef struct packed {
    logic       channel_enable;
    logic       regulation_mode;
    logic       invert;
    logic [6:0] threshold;
    logic [5:0] hysteresis;
    logic [7:0] cutoff;
    logic [6:0] gain;
    logic       output_assigned;
  } htr_cfg_t;

  typedef struct packed {
    logic              drive;
    logic [DUTY_W-1:0] duty;
    logic              allowed;
    logic [1:0]        band_exit;
  } htr_state_t;

endpackage

// ----- design/htr_core.sv -----
`timescale 1ns / 1ps
module htr_core import htr_pkg::*; (
  input  htr_cfg_t               cfg,
  input  logic [SAMPLE_BITS-1:0] raw_sample,
  input  logic                   sensor_kind,
  input  logic                   sensor_ok,
  input  htr_state_t             state_cur,
  output htr_state_t             state_nxt,
  output logic                   force_off
);

  logic [SAMPLE_BITS-2:0]   half;
  logic signed [RD_W-1:0]   rd;
  logic signed [RD_W-1:0]   lo;
  logic signed [RD_W-1:0]   hi;
  logic signed [RD_W-1:0]   cut_m1;
  logic signed [RD_W-1:0]   diff;
  logic signed [7:0]        gain_s;
  logic signed [PROD_W-1:0] prod;
  logic [DUTY_W-1:0]        duty_clamped;
  logic                     on_side;
  logic                     off_side;
  logic                     exit_flag;

  assign half   = raw_sample[SAMPLE_BITS-1:1];
  assign rd     = (sensor_kind == 1'b1) ? $signed(RD_W'(raw_sample)) :
                  (half >= (SAMPLE_BITS-1)'(TEMP_LIMIT)) ? $signed(RD_W'(TEMP_CLAMPED)) :
                  $signed(RD_W'(half));
  assign lo     = $signed(RD_W'(cfg.threshold)) - $signed(RD_W'(cfg.hysteresis));
  assign hi     = $signed(RD_W'(cfg.threshold)) + $signed(RD_W'(cfg.hysteresis));
  assign cut_m1 = $signed(RD_W'(cfg.cutoff)) - $signed(RD_W'(1));

  // Distance from the band edge on the drive-off side, scaled by the gain.
  assign diff   = cfg.invert ? (rd - lo) : (hi - rd);
  assign gain_s = $signed({1'b0, cfg.gain});
  assign prod   = diff * gain_s;

  always_comb begin
    if (prod < $signed(PROD_W'(0))) begin
      duty_clamped = '0;
    end else if (prod > $signed(PROD_W'(DUTY_MAX))) begin
      duty_clamped = DUTY_W'(DUTY_MAX);
    end else begin
      duty_clamped = prod[DUTY_W-1:0];
    end
  end

  // Heating turns on at or below the low edge; cooling mirrors it.
  assign on_side   = cfg.invert ? (rd >= hi) : (rd <= lo);
  assign off_side  = cfg.invert ? (rd < lo) : (rd > hi);
  assign exit_flag = state_cur.band_exit[cfg.regulation_mode];

  always_comb begin
    state_nxt = state_cur;
    force_off = 1'b0;
    if (cfg.channel_enable && cfg.output_assigned) begin
      if (!sensor_ok) begin
        // A temperature fault drops the drive; a humidity fault holds all.
        if (!sensor_kind) begin
          state_nxt.drive = 1'b0;
        end
      end else begin
        if (cfg.regulation_mode) begin
          state_nxt.duty = duty_clamped;
        end
        if (on_side) begin
          state_nxt.drive = 1'b1;
          state_nxt.band_exit[cfg.regulation_mode] = 1'b0;
        end else if (off_side) begin
          state_nxt.drive = 1'b0;
          state_nxt.band_exit[cfg.regulation_mode] = 1'b1;
        end else begin
          state_nxt.drive = !exit_flag;
        end
        if (rd >= cut_m1) begin
          state_nxt.allowed = 1'b0;
          force_off = 1'b1;
        end else begin
          state_nxt.allowed = 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/hysteresis_thermostat_regulator.sv -----
`timescale 1ns / 1ps
// Single-channel thermostat regulator with hysteresis and proportional duty.
// Input channel: in_valid/in_stall carry one sensor reading per item
// (in_raw_sample, in_sensor_kind, in_sensor_ok). Each item gives exactly one
// result item on out_valid/out_stall: drive on/off, duty percent, output
// allowed flag and a one-item force-off pulse.
// Configuration: cfg_we writes cfg_wdata into register cfg_index at a clock
// edge; write only while no item is in flight.
// The result is registered: one input register, then the decision logic
// (compare, one small multiply, clamp) feeding the regulator state and
// result registers. Throughput is one item per cycle while the receiver
// does not stall; the regulator state updated by one item is used by the
// next item.
// When the receiver stalls, the result holds and one more item may wait in
// the input register; after that in_stall rises until the result is taken.
// Synchronous reset (rst_n low) empties both stages and restores the
// register defaults and the regulator state: drive off, duty 100, output
// allowed, band exit flags clear.
`include "hysteresis_thermostat_regulator_assert.svh"
module hysteresis_thermostat_regulator import htr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_raw_sample,
  input  logic                   in_sensor_kind,
  input  logic                   in_sensor_ok,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_drive_on,
  output logic [DUTY_W-1:0]      out_duty_percent,
  output logic                   out_output_allowed,
  output logic                   out_force_off,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  htr_cfg_t               cfg_r;
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic [SAMPLE_BITS-1:0] s1_raw_r;
  logic                   s1_kind_r;
  logic                   s1_ok_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   force_off_r;
  logic                   force_off_nxt;
  htr_state_t             state_r;
  htr_state_t             state_nxt;
  logic                   in_take;
  logic                   advance;

  // The result stage can take a new item whenever it is empty or being read.
  assign advance  = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Configuration registers; every index names one register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_enable  <= 1'b0;
      cfg_r.regulation_mode <= 1'b0;
      cfg_r.invert          <= 1'b0;
      cfg_r.threshold       <= 7'd25;
      cfg_r.hysteresis      <= 6'd0;
      cfg_r.cutoff          <= 8'd100;
      cfg_r.gain            <= 7'd10;
      cfg_r.output_assigned <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_ENABLE:  cfg_r.channel_enable  <= cfg_wdata[0];
        REG_REGULATION_MODE: cfg_r.regulation_mode <= cfg_wdata[0];
        REG_INVERT:          cfg_r.invert          <= cfg_wdata[0];
        REG_THRESHOLD:       cfg_r.threshold       <= cfg_wdata[6:0];
        REG_HYSTERESIS:      cfg_r.hysteresis      <= cfg_wdata[5:0];
        REG_CUTOFF:          cfg_r.cutoff          <= cfg_wdata[7:0];
        REG_GAIN:            cfg_r.gain            <= cfg_wdata[6:0];
        REG_OUTPUT_ASSIGNED: cfg_r.output_assigned <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_raw_r  <= in_raw_sample;
      s1_kind_r <= in_sensor_kind;
      s1_ok_r   <= in_sensor_ok;
    end
  end

  htr_core u_core (
    .cfg         (cfg_r),
    .raw_sample  (s1_raw_r),
    .sensor_kind (s1_kind_r),
    .sensor_ok   (s1_ok_r),
    .state_cur   (state_r),
    .state_nxt   (state_nxt),
    .force_off   (force_off_nxt)
  );

  // The regulator state doubles as the result payload: it only moves when a
  // new result is loaded, so a stalled result stays put.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r       <= 1'b0;
      force_off_r       <= 1'b0;
      state_r.drive     <= 1'b0;
      state_r.duty      <= DUTY_W'(DUTY_RESET);
      state_r.allowed   <= 1'b1;
      state_r.band_exit <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        force_off_r <= force_off_nxt;
        state_r     <= state_nxt;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive_on       = state_r.drive;
  assign out_duty_percent   = state_r.duty;
  assign out_output_allowed = state_r.allowed;
  assign out_force_off      = force_off_r;

  `HTR_ASSERT_IMPL(a_duty_range, clk, rst_n, 1'b1, state_r.duty <= DUTY_W'(DUTY_MAX))
  `HTR_ASSERT_IMPL(a_force_blocks, clk, rst_n, out_valid_r && force_off_r, !state_r.allowed)
  `HTR_ASSERT_IMPL(a_stall_full, clk, rst_n, in_stall, s1_valid_r && out_valid_r)
  `HTR_ASSERT_NEXT(a_state_hold, clk, rst_n, !advance, $stable(state_r) && $stable(force_off_r))

endmodule

// ----- tb/hysteresis_thermostat_regulator_tb.sv -----
`timescale 1ns / 1ps
module hysteresis_thermostat_regulator_tb;
  import htr_pkg::*;

  // Sensor kinds as they appear on in_sensor_kind.
  localparam logic KIND_TEMP  = 1'b0;
  localparam logic KIND_HUMID = 1'b1;

  // One sensor reading as it is presented on the input channel.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raw;
    logic                   kind;
    logic                   ok;
  } reading_t;

  // One regulator decision as it leaves on the result channel.
  typedef struct packed {
    logic              drive;
    logic [DUTY_W-1:0] duty;
    logic              allowed;
    logic              force_off;
  } decision_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] in_raw_sample;
  logic                   in_sensor_kind;
  logic                   in_sensor_ok;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_drive_on;
  logic [DUTY_W-1:0]      out_duty_percent;
  logic                   out_output_allowed;
  logic                   out_force_off;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // Readings waiting to be sent, and decisions waiting to be received.
  reading_t  queued_readings[$];
  decision_t predicted_decisions[$];

  // Shadow copy of the register file and of the regulator state.
  htr_cfg_t          shadow_cfg;
  logic              shadow_drive;
  logic [DUTY_W-1:0] shadow_duty;
  logic              shadow_allowed;
  logic [1:0]        shadow_band_exit;

  // Percent chance per cycle that the sender idles or the receiver stalls.
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  // High in the cycle after a reading was taken by the block.
  logic     reading_taken;
  reading_t next_reading;
  int       mismatch_count;

  hysteresis_thermostat_regulator i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_sample      (in_raw_sample),
    .in_sensor_kind     (in_sensor_kind),
    .in_sensor_ok       (in_sensor_ok),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_drive_on       (out_drive_on),
    .out_duty_percent   (out_duty_percent),
    .out_output_allowed (out_output_allowed),
    .out_force_off      (out_force_off),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block stops answering. A correct run needs well
  // under a tenth of this.
  initial begin
    #5_000_000;
    $display("hysteresis_thermostat_regulator_tb failed");
    $finish;
  end

  // Works out the decision that one accepted reading must produce and moves
  // the shadow state along with it.
  function automatic decision_t regulate_reading(reading_t r);
    decision_t res;
    int        level;
    int        band_lo;
    int        band_hi;
    int        duty_calc;
    logic      sel;
    res.force_off = 1'b0;
    // A disabled or unassigned channel holds everything.
    if (shadow_cfg.channel_enable && shadow_cfg.output_assigned) begin
      if (!r.ok) begin
        // A temperature fault drops the drive; a humidity fault holds it.
        if (r.kind == KIND_TEMP) shadow_drive = 1'b0;
      end else begin
        if (r.kind == KIND_HUMID) begin
          level = int'(r.raw);
        end else begin
          level = int'(r.raw >> 1);
          if (level >= TEMP_LIMIT) level = TEMP_CLAMPED;
        end
        // The lower edge goes negative when the hysteresis exceeds the
        // threshold, so all of this is done in plain integers.
        band_lo = int'(shadow_cfg.threshold) - int'(shadow_cfg.hysteresis);
        band_hi = int'(shadow_cfg.threshold) + int'(shadow_cfg.hysteresis);
        sel = shadow_cfg.regulation_mode;
        if (sel) begin
          duty_calc = shadow_cfg.invert ? level - band_lo : band_hi - level;
          duty_calc = duty_calc * int'(shadow_cfg.gain);
          if (duty_calc < 0) duty_calc = 0;
          else if (duty_calc > DUTY_MAX) duty_calc = DUTY_MAX;
          shadow_duty = duty_calc[DUTY_W-1:0];
        end
        // Each mode keeps its own memory of which side the band was left on.
        if (!shadow_cfg.invert) begin
          if (level <= band_lo) begin
            shadow_drive = 1'b1;
            shadow_band_exit[sel] = 1'b0;
          end else if (level <= band_hi) begin
            shadow_drive = !shadow_band_exit[sel];
          end else begin
            shadow_drive = 1'b0;
            shadow_band_exit[sel] = 1'b1;
          end
        end else begin
          if (level >= band_hi) begin
            shadow_drive = 1'b1;
            shadow_band_exit[sel] = 1'b0;
          end else if (level >= band_lo) begin
            shadow_drive = !shadow_band_exit[sel];
          end else begin
            shadow_drive = 1'b0;
            shadow_band_exit[sel] = 1'b1;
          end
        end
        // With a cutoff of zero the limit is minus one and every reading trips.
        if (level >= int'(shadow_cfg.cutoff) - 1) begin
          shadow_allowed = 1'b0;
          res.force_off = 1'b1;
        end else begin
          shadow_allowed = 1'b1;
        end
      end
    end
    res.drive   = shadow_drive;
    res.duty    = shadow_duty;
    res.allowed = shadow_allowed;
    return res;
  endfunction

  function automatic void queue_reading(int raw, logic kind, logic ok);
    reading_t r;
    r.raw  = raw[SAMPLE_BITS-1:0];
    r.kind = kind;
    r.ok   = ok;
    queued_readings.push_back(r);
  endfunction

  // Most readings land close to a band edge or to the cutoff so that the
  // hysteresis memory is exercised; the rest are anywhere in the raw range.
  function automatic void queue_random_reading();
    reading_t r;
    int       target;
    int       roll;
    roll   = $urandom_range(99);
    r.kind = 1'($urandom_range(1));
    r.ok   = ($urandom_range(9) != 0);
    if (roll < 25) begin
      r.raw = SAMPLE_BITS'($urandom_range(2 ** SAMPLE_BITS - 1));
    end else begin
      if (roll < 40) begin
        target = int'(shadow_cfg.cutoff) - 1;
      end else begin
        case ($urandom_range(2))
          0: target = int'(shadow_cfg.threshold) - int'(shadow_cfg.hysteresis);
          1: target = int'(shadow_cfg.threshold) + int'(shadow_cfg.hysteresis);
          default: target = int'(shadow_cfg.threshold);
        endcase
      end
      target = target + int'($urandom_range(8)) - 4;
      if (target < 0) target = 0;
      // A temperature reading is in half degrees, so scale it back up.
      if (r.kind == KIND_HUMID) r.raw = target[SAMPLE_BITS-1:0];
      else if (target > 255) r.raw = '1;
      else r.raw = SAMPLE_BITS'(2 * target + int'($urandom_range(1)));
    end
    queued_readings.push_back(r);
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: mismatch: %s", $time, msg);
  endfunction

  // Writes one register and keeps the shadow copy in step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    logic [CFG_DATA_W-1:0] data;
    data = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      REG_CHANNEL_ENABLE:  shadow_cfg.channel_enable  = data[0];
      REG_REGULATION_MODE: shadow_cfg.regulation_mode = data[0];
      REG_INVERT:          shadow_cfg.invert          = data[0];
      REG_THRESHOLD:       shadow_cfg.threshold       = data[6:0];
      REG_HYSTERESIS:      shadow_cfg.hysteresis      = data[5:0];
      REG_CUTOFF:          shadow_cfg.cutoff          = data;
      REG_GAIN:            shadow_cfg.gain            = data[6:0];
      REG_OUTPUT_ASSIGNED: shadow_cfg.output_assigned = data[0];
      default: ;
    endcase
  endtask

  // Rewrites the whole register file. Only called with nothing in flight.
  task automatic program_channel(int en, int mode, int inv, int thr, int hyst,
                                 int cut, int gn, int asg);
    write_reg(REG_CHANNEL_ENABLE, en);
    write_reg(REG_REGULATION_MODE, mode);
    write_reg(REG_INVERT, inv);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_HYSTERESIS, hyst);
    write_reg(REG_CUTOFF, cut);
    write_reg(REG_GAIN, gn);
    write_reg(REG_OUTPUT_ASSIGNED, asg);
    @(negedge clk);
    cfg_we = 1'b0;
    // Readings for the new setting are queued just after a rising edge so
    // that the driver first sees them at the following falling edge.
    @(posedge clk);
  endtask

  // Holds the test back until every queued reading has been sent and
  // every predicted decision has come back, then lets the pipeline settle.
  // The check runs on the rising edge, where the driven inputs are steady.
  task automatic wait_for_drain();
    do @(posedge clk);
    while (queued_readings.size() != 0 || in_valid || predicted_decisions.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // Sender and receiver. Inputs change on the falling edge only; a reading
  // stays on the port until the block has taken it.
  always @(negedge clk) begin
    if (!in_valid || reading_taken) begin
      if (queued_readings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_reading = queued_readings.pop_front();
        in_valid       <= 1'b1;
        in_raw_sample  <= next_reading.raw;
        in_sensor_kind <= next_reading.kind;
        in_sensor_ok   <= next_reading.ok;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watches both channels on the rising edge. A decision is checked before
  // the reading taken at the same edge is predicted; each reading passes the
  // input and result registers first, so the two never belong to the same item.
  always @(posedge clk) begin
    decision_t want;
    if (!rst_n) begin
      reading_taken <= 1'b0;
    end else begin
      reading_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (predicted_decisions.size() == 0) begin
          flag_mismatch($sformatf("decision drive=%0d duty=%0d allowed=%0d force_off=%0d %s",
                                  out_drive_on, out_duty_percent, out_output_allowed,
                                  out_force_off, "arrived with none expected"));
        end else begin
          want = predicted_decisions.pop_front();
          if (out_drive_on !== want.drive)
            flag_mismatch($sformatf("drive_on expected %0d got %0d",
                                    want.drive, out_drive_on));
          if (out_duty_percent !== want.duty)
            flag_mismatch($sformatf("duty_percent expected %0d got %0d",
                                    want.duty, out_duty_percent));
          if (out_output_allowed !== want.allowed)
            flag_mismatch($sformatf("output_allowed expected %0d got %0d",
                                    want.allowed, out_output_allowed));
          if (out_force_off !== want.force_off)
            flag_mismatch($sformatf("force_off expected %0d got %0d",
                                    want.force_off, out_force_off));
        end
      end
      if (in_valid && !in_stall)
        predicted_decisions.push_back(regulate_reading({in_raw_sample, in_sensor_kind,
                                                        in_sensor_ok}));
    end
  end

  initial begin
    int en;
    int mode;
    int inv;
    int thr;
    int hyst;
    int cut;
    int gn;
    int asg;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_raw_sample  = '0;
    in_sensor_kind = KIND_TEMP;
    in_sensor_ok   = 1'b1;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_CHANNEL_ENABLE;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    mismatch_count = 0;
    // Register defaults and regulator state as they are after reset.
    shadow_cfg           = '0;
    shadow_cfg.threshold = 7'd25;
    shadow_cfg.cutoff    = 8'd100;
    shadow_cfg.gain      = 7'd10;
    shadow_drive         = 1'b0;
    shadow_duty          = DUTY_W'(DUTY_RESET);
    shadow_allowed       = 1'b1;
    shadow_band_exit     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Heating on/off around 25 with a band of 22..28. The first reading sits
    // inside the band with nothing remembered yet, then the band is left on
    // the high side and re-entered, and the low edge is hit exactly. The
    // temperature readings cover zero, the clamp to 101 and the cutoff edge.
    program_channel(1, 0, 0, 25, 3, 100, 10, 1);
    queue_reading(25, KIND_HUMID, 1'b1);
    queue_reading(29, KIND_HUMID, 1'b1);
    queue_reading(25, KIND_HUMID, 1'b1);
    queue_reading(22, KIND_HUMID, 1'b1);
    queue_reading(0, KIND_TEMP, 1'b1);
    queue_reading(511, KIND_TEMP, 1'b1);
    queue_reading(199, KIND_TEMP, 1'b1);
    queue_reading(40, KIND_TEMP, 1'b0);
    queue_reading(40, KIND_HUMID, 1'b0);
    queue_reading(511, KIND_HUMID, 1'b1);
    wait_for_drain();

    // Proportional cooling with a negative lower edge, a zero cutoff so that
    // every reading trips, and the largest gain the register holds.
    program_channel(1, 1, 1, 0, 63, 0, 127, 1);
    queue_reading(0, KIND_HUMID, 1'b1);
    queue_reading(63, KIND_HUMID, 1'b1);
    queue_reading(64, KIND_HUMID, 1'b1);
    queue_reading(20, KIND_TEMP, 1'b1);
    wait_for_drain();

    // Proportional heating: the duty falls from full through zero and is
    // clamped once the reading passes the upper edge; the top cutoff is hit
    // only by a wide humidity reading.
    program_channel(1, 1, 0, 10, 2, 255, 100, 1);
    queue_reading(5, KIND_HUMID, 1'b1);
    queue_reading(12, KIND_HUMID, 1'b1);
    queue_reading(13, KIND_HUMID, 1'b1);
    queue_reading(250, KIND_HUMID, 1'b1);
    queue_reading(254, KIND_HUMID, 1'b1);
    wait_for_drain();

    // A disabled channel and then an unassigned one must hold everything.
    program_channel(0, 0, 0, 25, 3, 100, 10, 1);
    queue_reading(0, KIND_HUMID, 1'b1);
    queue_reading(300, KIND_TEMP, 1'b0);
    wait_for_drain();
    program_channel(1, 0, 0, 25, 3, 100, 10, 0);
    queue_reading(0, KIND_TEMP, 1'b1);
    queue_reading(500, KIND_HUMID, 1'b1);
    wait_for_drain();

    // Random phases. The first two pin every numeric register to its lowest
    // and highest value; the rest pick settings at random. The handshake
    // pressure rotates through no idling, sender gaps, receiver stalls and
    // both together, and each phase ends by draining the pipeline.
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 54; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 54; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      en   = int'($urandom_range(7) != 0);
      asg  = int'($urandom_range(7) != 0);
      mode = $urandom_range(1);
      inv  = $urandom_range(1);
      thr  = $urandom_range(127);
      hyst = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(12);
      cut  = ($urandom_range(1) != 0) ? thr + $urandom_range(40) : $urandom_range(255);
      if (cut > 255) cut = 255;
      gn   = $urandom_range(100);
      if (p == 0) begin
        en = 1; asg = 1; thr = 0; hyst = 0; cut = 0; gn = 0;
      end else if (p == 1) begin
        en = 1; asg = 1; thr = 127; hyst = 63; cut = 255; gn = 127;
      end
      program_channel(en, mode, inv, thr, hyst, cut, gn, asg);
      repeat (66) queue_random_reading();
      wait_for_drain();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && predicted_decisions.size() == 0) begin
      $display("hysteresis_thermostat_regulator_tb passed");
    end else begin
      $display("hysteresis_thermostat_regulator_tb failed");
    end
    $finish;
  end

endmodule
